>>> rtl/core/mcpf_pkg.sv
// ----------------------------------------------------------------------------
// mcpf_pkg
// Shared types and constants for the multi-channel pipe fifo core
// ----------------------------------------------------------------------------
package mcpf_pkg;

    localparam int SLOT_MAX = 16;
    localparam int CH_W     = 4;
    localparam int DATA_W   = 8;
    localparam int ACT_W    = 3;
    localparam int STAT_W   = 3;

    localparam logic [ACT_W-1:0] ACT_ALLOC = 3'd0;
    localparam logic [ACT_W-1:0] ACT_ADD   = 3'd1;
    localparam logic [ACT_W-1:0] ACT_DROP  = 3'd2;
    localparam logic [ACT_W-1:0] ACT_WRITE = 3'd3;
    localparam logic [ACT_W-1:0] ACT_READ  = 3'd4;

    localparam logic [STAT_W-1:0] ST_OK     = 3'd0;
    localparam logic [STAT_W-1:0] ST_BAD    = 3'd1;
    localparam logic [STAT_W-1:0] ST_BROKEN = 3'd2;
    localparam logic [STAT_W-1:0] ST_FULL   = 3'd3;
    localparam logic [STAT_W-1:0] ST_EOF    = 3'd4;
    localparam logic [STAT_W-1:0] ST_BLOCK  = 3'd5;
    localparam logic [STAT_W-1:0] ST_NOFREE = 3'd6;

    typedef struct packed {
        logic [ACT_W-1:0]  action;
        logic [CH_W-1:0]   channel;
        logic              end_is_write;
        logic [DATA_W-1:0] data_in;
        logic              last;
    } t_req;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [DATA_W-1:0] data_out;
        logic [CH_W-1:0]   channel_out;
        logic              wake_reader;
        logic              last_out;
    } t_rsp;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_LOAD
    } t_state;

    typedef struct packed {
        logic load_item;
        logic exec;
        logic load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic out_free;
    } t_dp_stat;

endpackage

>>> rtl/core/mcpf_stream_if.sv
// ----------------------------------------------------------------------------
// mcpf_stream_if
// Valid/ready channel carrying one payload of a given type
// ----------------------------------------------------------------------------
interface mcpf_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/core/mcpf_ctrl.sv
// ----------------------------------------------------------------------------
// mcpf_ctrl
// Sequencer for one request: accept, execute, hand result to output register
// ----------------------------------------------------------------------------
module mcpf_ctrl
    import mcpf_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_req_valid,
    input  t_dp_stat i_stat,
    output logic     o_req_ready,
    output t_dp_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_LOAD;
            end
            S_LOAD: begin
                if (i_stat.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_req_ready    = 1'b0;
        o_cmd          = '0;
        case (r_state)
            S_IDLE: begin
                o_req_ready     = 1'b1;
                o_cmd.load_item = i_req_valid;
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
            end
            S_LOAD: begin
                o_cmd.load_out = i_stat.out_free;
            end
            default: begin
                o_req_ready = 1'b0;
            end
        endcase
    end

endmodule

>>> rtl/core/mcpf_dp.sv
// ----------------------------------------------------------------------------
// mcpf_dp
// Channel table, byte store and result registers
// ----------------------------------------------------------------------------
module mcpf_dp
    import mcpf_pkg::*;
#(
    parameter int LIVE_CH   = 16,
    parameter int BUF_BYTES = 4096,
    parameter int REF_MAX   = 255
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_dp_cmd  i_cmd,
    input  t_req     i_req_data,
    input  logic     i_rsp_ready,
    output logic     o_rsp_valid,
    output t_rsp     o_rsp_data,
    output t_dp_stat o_stat
);

    localparam int CW        = (LIVE_CH > 1) ? $clog2(LIVE_CH) : 1;
    localparam int NSLOT     = 2 ** CW;
    localparam int PW        = $clog2(BUF_BYTES);
    localparam int FW        = $clog2(BUF_BYTES + 1);
    localparam int SW        = FW + 1;
    localparam int RW        = $clog2(REF_MAX + 1);
    localparam int MEM_DEPTH = 2 ** (CW + PW);

    t_req r_item;

    logic          r_in_use [NSLOT];
    logic [PW-1:0] r_rpos   [NSLOT];
    logic [FW-1:0] r_fill   [NSLOT];
    logic [RW-1:0] r_rr     [NSLOT];
    logic [RW-1:0] r_wr     [NSLOT];
    logic          r_park   [NSLOT];

    logic [DATA_W-1:0] mem [MEM_DEPTH];
    logic [DATA_W-1:0] r_rd_data;

    logic [STAT_W-1:0] r_res_status;
    logic [CH_W-1:0]   r_res_chout;
    logic              r_res_wake;
    logic              r_res_rd;
    logic              r_res_last;

    logic r_out_valid;
    t_rsp r_out;

    logic [CW-1:0] ch_idx;
    logic          ch_ok;
    logic          found;
    logic [CW-1:0] free_idx;

    logic          cur_park;
    logic [PW-1:0] cur_rpos;
    logic [FW-1:0] cur_fill;
    logic [RW-1:0] cur_rr;
    logic [RW-1:0] cur_wr;

    logic          upd;
    logic [CW-1:0] upd_idx;
    logic          n_use;
    logic [PW-1:0] n_rpos;
    logic [FW-1:0] n_fill;
    logic [RW-1:0] n_rr;
    logic [RW-1:0] n_wr;
    logic          n_park;

    logic [STAT_W-1:0] n_res_status;
    logic [CH_W-1:0]   n_res_chout;
    logic              n_res_wake;
    logic              n_res_rd;

    logic              wr_en;
    logic [SW-1:0]     w_sum;
    logic [PW-1:0]     w_tail;

    assign ch_idx   = r_item.channel[CW-1:0];
    assign ch_ok    = ({1'b0, r_item.channel} < (CH_W + 1)'(LIVE_CH)) && r_in_use[ch_idx];
    assign cur_park = r_park[ch_idx];
    assign cur_rpos = r_rpos[ch_idx];
    assign cur_fill = r_fill[ch_idx];
    assign cur_rr   = r_rr[ch_idx];
    assign cur_wr   = r_wr[ch_idx];

    assign w_sum  = SW'(cur_rpos) + SW'(cur_fill);
    assign w_tail = (w_sum >= SW'(BUF_BYTES)) ? PW'(w_sum - SW'(BUF_BYTES)) : PW'(w_sum);

    // lowest free channel
    always_comb begin
        found    = 1'b0;
        free_idx = '0;
        for (int i = LIVE_CH - 1; i >= 0; i--) begin
            if (!r_in_use[i]) begin
                found    = 1'b1;
                free_idx = CW'(i);
            end
        end
    end

    always_comb begin
        upd          = 1'b0;
        upd_idx      = ch_idx;
        n_use        = 1'b1;
        n_rpos       = cur_rpos;
        n_fill       = cur_fill;
        n_rr         = cur_rr;
        n_wr         = cur_wr;
        n_park       = cur_park;
        n_res_status = ST_OK;
        n_res_chout  = '0;
        n_res_wake   = 1'b0;
        n_res_rd     = 1'b0;
        wr_en        = 1'b0;
        case (r_item.action)
            ACT_ALLOC: begin
                if (found) begin
                    upd         = 1'b1;
                    upd_idx     = free_idx;
                    n_rpos      = '0;
                    n_fill      = '0;
                    n_rr        = RW'(1);
                    n_wr        = RW'(1);
                    n_park      = 1'b0;
                    n_res_chout = CH_W'(free_idx);
                end else begin
                    n_res_status = ST_NOFREE;
                end
            end
            ACT_ADD: begin
                if (!ch_ok) begin
                    n_res_status = ST_BAD;
                end else begin
                    upd = 1'b1;
                    if (r_item.end_is_write) begin
                        if (cur_wr < RW'(REF_MAX)) begin
                            n_wr = cur_wr + RW'(1);
                        end
                    end else begin
                        if (cur_rr < RW'(REF_MAX)) begin
                            n_rr = cur_rr + RW'(1);
                        end
                    end
                end
            end
            ACT_DROP: begin
                if (!ch_ok) begin
                    n_res_status = ST_BAD;
                end else begin
                    upd = 1'b1;
                    if (r_item.end_is_write) begin
                        if (cur_wr != '0) begin
                            n_wr = cur_wr - RW'(1);
                        end
                        if (n_wr == '0) begin
                            n_res_wake = cur_park;
                            n_park     = 1'b0;
                        end
                    end else begin
                        if (cur_rr != '0) begin
                            n_rr = cur_rr - RW'(1);
                        end
                    end
                    if (n_rr == '0 && n_wr == '0) begin
                        n_use  = 1'b0;
                        n_park = 1'b0;
                    end
                end
            end
            ACT_WRITE: begin
                if (!ch_ok) begin
                    n_res_status = ST_BAD;
                end else if (cur_rr == '0) begin
                    n_res_status = ST_BROKEN;
                end else if (cur_fill >= FW'(BUF_BYTES)) begin
                    n_res_status = ST_FULL;
                end else begin
                    upd        = 1'b1;
                    wr_en      = 1'b1;
                    n_fill     = cur_fill + FW'(1);
                    n_res_wake = cur_park;
                    n_park     = 1'b0;
                end
            end
            ACT_READ: begin
                if (!ch_ok) begin
                    n_res_status = ST_BAD;
                end else if (cur_fill != '0) begin
                    upd      = 1'b1;
                    n_res_rd = 1'b1;
                    n_fill   = cur_fill - FW'(1);
                    n_rpos   = (cur_rpos == PW'(BUF_BYTES - 1)) ? '0 : cur_rpos + PW'(1);
                end else if (cur_wr == '0) begin
                    n_res_status = ST_EOF;
                end else begin
                    upd          = 1'b1;
                    n_res_status = ST_BLOCK;
                    n_park       = 1'b1;
                end
            end
            default: begin
                n_res_status = ST_BAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_item <= i_req_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NSLOT; i++) begin
                r_in_use[i] <= 1'b0;
                r_rpos[i]   <= '0;
                r_fill[i]   <= '0;
                r_rr[i]     <= '0;
                r_wr[i]     <= '0;
                r_park[i]   <= 1'b0;
            end
        end else if (i_cmd.exec && upd) begin
            r_in_use[upd_idx] <= n_use;
            r_rpos[upd_idx]   <= n_rpos;
            r_fill[upd_idx]   <= n_fill;
            r_rr[upd_idx]     <= n_rr;
            r_wr[upd_idx]     <= n_wr;
            r_park[upd_idx]   <= n_park;
        end
    end

    // byte store
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && wr_en) begin
            mem[{ch_idx, w_tail}] <= r_item.data_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && n_res_rd) begin
            r_rd_data <= mem[{ch_idx, cur_rpos}];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_res_status <= n_res_status;
            r_res_chout  <= n_res_chout;
            r_res_wake   <= n_res_wake;
            r_res_rd     <= n_res_rd;
            r_res_last   <= r_item.last;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_rsp_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out.status      <= r_res_status;
            r_out.data_out    <= r_res_rd ? r_rd_data : '0;
            r_out.channel_out <= r_res_chout;
            r_out.wake_reader <= r_res_wake;
            r_out.last_out    <= r_res_last;
        end
    end

    assign o_stat.out_free = !r_out_valid || i_rsp_ready;
    assign o_rsp_valid     = r_out_valid;
    assign o_rsp_data      = r_out;

endmodule

>>> rtl/core/multi_channel_pipe_fifo_core.sv
// ----------------------------------------------------------------------------
// multi_channel_pipe_fifo_core
// Table of byte pipe channels with reference counts, one action per request
//
//   port   dir  payload  role
//   i_req  in   t_req    action request: allocate, ref add/drop, write, read
//   o_rsp  out  t_rsp    one result per request
//
// Each request passes through accept, execute against the channel table
// and byte store, then load of the output register; the registered store
// read sets the last step. One request is in flight at a time; a new one is
// taken while the previous result still waits in the output register.
// Synchronous reset clears the channel table; the byte store is not cleared.
// A stall on o_rsp holds the sequencer until the output register is free.
// ----------------------------------------------------------------------------
module multi_channel_pipe_fifo_core
    import mcpf_pkg::*;
#(
    parameter int CHANNELS  = 16,
    parameter int BUF_BYTES = 4096,
    parameter int REF_MAX   = 255
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    mcpf_stream_if.sink         i_req,
    mcpf_stream_if.source       o_rsp
);

    localparam int LIVE_CH = (CHANNELS < SLOT_MAX) ? CHANNELS : SLOT_MAX;

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;
    logic     w_req_ready;
    logic     w_rsp_valid;
    t_rsp     w_rsp_data;

    mcpf_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .i_stat      (w_stat),
        .o_req_ready (w_req_ready),
        .o_cmd       (w_cmd)
    );

    mcpf_dp #(
        .LIVE_CH   (LIVE_CH),
        .BUF_BYTES (BUF_BYTES),
        .REF_MAX   (REF_MAX)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_req_data  (i_req.data),
        .i_rsp_ready (o_rsp.ready),
        .o_rsp_valid (w_rsp_valid),
        .o_rsp_data  (w_rsp_data),
        .o_stat      (w_stat)
    );

    assign i_req.ready = w_req_ready;
    assign o_rsp.valid = w_rsp_valid;
    assign o_rsp.data  = w_rsp_data;

`ifndef SYNTHESIS
    a_single_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready) |=> !i_req.ready)
        else $error("request accepted while previous one still executing");

    a_load_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.load_out |=> o_rsp.valid)
        else $error("result load did not raise response valid");

    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid |-> (o_rsp.data.status <= ST_NOFREE))
        else $error("response status out of range");

    a_exec_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.load_item |=> w_cmd.exec)
        else $error("accepted request not executed next cycle");
`endif

endmodule
